// File: rtl/rmth_pkg.sv
// Package for the running median store: types, constants and codes.
package rmth_pkg;

  localparam int Capacity    = 1024;
  localparam int ValueWidth  = 32;
  localparam int HeapDepth   = Capacity / 2 + 1;
  localparam int AddrWidth   = $clog2(HeapDepth);
  localparam int CountWidth  = $clog2(HeapDepth + 1);
  localparam int TotalWidth  = $clog2(Capacity + 1);

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MEDIAN   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] median_out;
    logic [10:0]        count_after;
  } rsp_t;

  // Heap operation requested from the datapath.
  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_PUSH,
    HOP_POP
  } hop_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_PUSH1,
    S_BAL,
    S_PUSH2,
    S_POP,
    S_POPDONE,
    S_OUT
  } state_t;

  // Sift engine states of one heap.
  typedef enum logic [2:0] {
    H_IDLE,
    H_UP_CMP,
    H_UP_WR,
    H_DN_LD,
    H_DN_RDL,
    H_DN_CMP,
    H_DONE
  } hstate_t;

  // Commands from controller to datapath.
  typedef struct packed {
    hop_t                  op;
    logic                  sel_upper;
    logic [ValueWidth-1:0] push_val;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [ValueWidth-1:0] pop_val;
  } stat_t;

  // Signed less-than on stored value patterns.
  function automatic logic val_lt(input logic [ValueWidth-1:0] a,
                                  input logic [ValueWidth-1:0] b);
    val_lt = $signed(a) < $signed(b);
  endfunction

endpackage

// File: rtl/rmth_heap.sv
// One heap (max or min) in a memory, with a push and pop sift engine.
module rmth_heap (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         is_max,
  input  logic                         start_push,
  input  logic                         start_pop,
  input  logic [rmth_pkg::ValueWidth-1:0] push_val,
  output logic [rmth_pkg::ValueWidth-1:0] top_val,
  output logic [rmth_pkg::CountWidth-1:0] count,
  output logic                         busy,
  output logic                         done
);
  import rmth_pkg::*;

  logic [ValueWidth-1:0] mem [HeapDepth];
  hstate_t               hst, hst_next;
  logic [AddrWidth-1:0]  idx, idx_next;
  logic [ValueWidth-1:0] cur, cur_next;
  logic [ValueWidth-1:0] lval, lval_next;
  logic [ValueWidth-1:0] rd_data;
  logic [AddrWidth-1:0]  rd_addr;
  logic                  we;
  logic [AddrWidth-1:0]  wa;
  logic [ValueWidth-1:0] wd;
  logic [CountWidth-1:0] cnt_next;
  logic [ValueWidth-1:0] top;
  logic [AddrWidth:0]    lidx, ridx;
  logic [AddrWidth-1:0]  pidx;
  logic                  has_l, has_r, l_wins, r_wins;

  function automatic logic above(input logic mx, input logic [ValueWidth-1:0] a,
                                 input logic [ValueWidth-1:0] b);
    above = mx ? val_lt(b, a) : val_lt(a, b);
  endfunction

  assign top_val = top;
  assign busy    = (hst != H_IDLE);
  assign done    = (hst == H_DONE);
  assign lidx    = {idx, 1'b1};
  assign ridx    = lidx + 1'b1;
  assign pidx    = (idx - 1'b1) >> 1;
  assign has_l   = (lidx < {1'b0, count});
  assign has_r   = (ridx < {1'b0, count});
  assign l_wins  = has_l && above(is_max, lval, cur);
  assign r_wins  = has_r && above(is_max, rd_data, l_wins ? lval : cur);

  // Memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[rd_addr];
  end

  // Sift control and write-port selection.
  always_comb begin
    hst_next  = hst;
    idx_next  = idx;
    cur_next  = cur;
    lval_next = lval;
    cnt_next  = count;
    rd_addr   = '0;
    we        = 1'b0;
    wa        = idx;
    wd        = cur;
    case (hst)
      H_IDLE: begin
        if (start_push) begin
          idx_next = count[AddrWidth-1:0];
          cur_next = push_val;
          cnt_next = count + 1'b1;
          if (count == '0) begin
            we = 1'b1; wa = '0; wd = push_val;
            hst_next = H_DONE;
          end else begin
            // Fetch the parent of the new slot.
            rd_addr  = AddrWidth'((count - 1'b1) >> 1);
            hst_next = H_UP_CMP;
          end
        end else if (start_pop) begin
          // Fetch the last entry, which refills the root.
          cnt_next = count - 1'b1;
          idx_next = '0;
          rd_addr  = AddrWidth'(count - 1'b1);
          hst_next = H_DN_LD;
        end
      end
      H_UP_CMP: begin
        // The parent moves down when the new value belongs above it.
        we = 1'b1;
        if (above(is_max, cur, rd_data)) begin
          wd       = rd_data;
          idx_next = pidx;
          if (pidx == '0) begin
            hst_next = H_UP_WR;
          end else begin
            rd_addr = (pidx - 1'b1) >> 1;
          end
        end else begin
          hst_next = H_DONE;
        end
      end
      H_UP_WR: begin
        // The new value settles at the root.
        we       = 1'b1;
        hst_next = H_DONE;
      end
      H_DN_LD: begin
        cur_next = rd_data;
        rd_addr  = AddrWidth'(lidx);
        hst_next = H_DN_RDL;
      end
      H_DN_RDL: begin
        lval_next = rd_data;
        rd_addr   = AddrWidth'(ridx);
        hst_next  = H_DN_CMP;
      end
      H_DN_CMP: begin
        // The winning child moves up and its left child is fetched next.
        we = 1'b1;
        if (r_wins) begin
          wd       = rd_data;
          idx_next = AddrWidth'(ridx);
          rd_addr  = {ridx[AddrWidth-2:0], 1'b1};
          hst_next = H_DN_RDL;
        end else if (l_wins) begin
          wd       = lval;
          idx_next = AddrWidth'(lidx);
          rd_addr  = {lidx[AddrWidth-2:0], 1'b1};
          hst_next = H_DN_RDL;
        end else begin
          hst_next = H_DONE;
        end
      end
      H_DONE: hst_next = H_IDLE;
      default: hst_next = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hst   <= H_IDLE;
      count <= '0;
    end else begin
      hst   <= hst_next;
      count <= cnt_next;
    end
  end

  // Sift registers; top follows every write to the root entry.
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    cur  <= cur_next;
    lval <= lval_next;
    if (we && wa == '0) top <= wd;
  end

endmodule

// File: rtl/rmth_datapath.sv
// Datapath: the two heaps, steered by heap commands from the controller.
module rmth_datapath (
  input  logic            clk,
  input  logic            rst,
  input  rmth_pkg::cmd_t  cmd,
  output rmth_pkg::stat_t stat,
  output logic [rmth_pkg::CountWidth-1:0] lower_count,
  output logic [rmth_pkg::CountWidth-1:0] upper_count
);
  import rmth_pkg::*;

  logic [ValueWidth-1:0] lo_top, up_top;
  logic lo_busy, up_busy, lo_done, up_done;

  rmth_heap u_lower (
    .clk, .rst, .is_max(1'b1),
    .start_push(cmd.op == HOP_PUSH && !cmd.sel_upper),
    .start_pop (cmd.op == HOP_POP  && !cmd.sel_upper),
    .push_val(cmd.push_val), .top_val(lo_top), .count(lower_count),
    .busy(lo_busy), .done(lo_done)
  );

  rmth_heap u_upper (
    .clk, .rst, .is_max(1'b0),
    .start_push(cmd.op == HOP_PUSH && cmd.sel_upper),
    .start_pop (cmd.op == HOP_POP  && cmd.sel_upper),
    .push_val(cmd.push_val), .top_val(up_top), .count(upper_count),
    .busy(up_busy), .done(up_done)
  );

  // Top is captured before a pop starts, so expose it live.
  assign stat.busy    = lo_busy | up_busy;
  assign stat.done    = lo_done | up_done;
  assign stat.pop_val = cmd.sel_upper ? up_top : lo_top;

endmodule

// File: rtl/rmth_ctrl.sv
// Controller: sequences heap operations for each request and forms the result.
module rmth_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rmth_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rmth_pkg::rsp_t  out_data,
  output rmth_pkg::cmd_t  cmd,
  input  rmth_pkg::stat_t stat,
  input  logic [rmth_pkg::CountWidth-1:0] lower_count,
  input  logic [rmth_pkg::CountWidth-1:0] upper_count
);
  import rmth_pkg::*;

  state_t                state, state_next;
  logic [ValueWidth-1:0] median, median_next;
  logic [TotalWidth-1:0] total, total_next;
  req_t                  req, req_next;
  rsp_t                  rsp, rsp_next;
  logic                  sel, sel_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = rsp;

  // Next state and heap commands.
  always_comb begin
    state_next   = state;
    median_next  = median;
    total_next   = total;
    req_next     = req;
    rsp_next     = rsp;
    sel_next     = sel;
    cmd.op       = HOP_NONE;
    cmd.sel_upper = sel;
    cmd.push_val = median;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next   = in_data;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rsp_next.median_out = '0;
        if (req.opcode == OP_INSERT) begin
          if (32'(total) >= Capacity) begin
            rsp_next.status = ST_FULL;
            state_next      = S_OUT;
          end else if (total == '0) begin
            median_next     = req.value;
            total_next      = total + 1'b1;
            rsp_next.status = ST_INSERTED;
            state_next      = S_OUT;
          end else begin
            cmd.op        = HOP_PUSH;
            cmd.sel_upper = !val_lt(req.value, median);
            cmd.push_val  = req.value;
            total_next    = total + 1'b1;
            rsp_next.status = ST_INSERTED;
            state_next    = S_PUSH1;
          end
        end else begin
          if (total == '0) begin
            rsp_next.status = ST_EMPTY;
            state_next      = S_OUT;
          end else begin
            rsp_next.status     = ST_MEDIAN;
            rsp_next.median_out = median;
            total_next          = total - 1'b1;
            if (upper_count > lower_count) begin
              sel_next = 1'b1; state_next = S_POP;
            end else if (lower_count == '0) begin
              median_next = '0; state_next = S_OUT;
            end else begin
              sel_next = 1'b0; state_next = S_POP;
            end
          end
        end
      end
      S_PUSH1: begin
        if (stat.done) state_next = S_BAL;
      end
      S_BAL: begin
        if (lower_count > upper_count) begin
          sel_next = 1'b0; cmd.op = HOP_PUSH; cmd.sel_upper = 1'b1;
          state_next = S_PUSH2;
        end else if ({1'b0, upper_count} > {1'b0, lower_count} + 1'b1) begin
          sel_next = 1'b1; cmd.op = HOP_PUSH; cmd.sel_upper = 1'b0;
          state_next = S_PUSH2;
        end else begin
          state_next = S_OUT;
        end
      end
      S_PUSH2: begin
        cmd.sel_upper = !sel;
        if (stat.done) state_next = S_POP;
      end
      S_POP: begin
        // Take the top, then start the pop sift.
        median_next = stat.pop_val;
        cmd.op      = HOP_POP;
        state_next  = S_POPDONE;
      end
      S_POPDONE: begin
        if (stat.done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // The count reported is the stored total after this request.
    rsp_next.count_after = 11'(total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      median      <= '0;
      total       <= '0;
      sel         <= 1'b0;
    end else begin
      state       <= state_next;
      median      <= median_next;
      total       <= total_next;
      sel         <= sel_next;
    end
  end

  always_ff @(posedge clk) begin
    req <= req_next;
    rsp <= rsp_next;
  end

endmodule

// File: rtl/running_median_two_heaps.sv
// Running median store: a lower max-heap, a median register and an upper min-heap.
// A request that touches no heap goes straight to its result; otherwise an insert
// pushes one heap, an extract pops one, and an insert that rebalances makes two
// pushes and a pop.
// One request is handled at a time; the next is taken in the cycle after the result
// is accepted. Reset (rst, synchronous) empties the store; heap memories are not cleared.
module running_median_two_heaps (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmth_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rmth_pkg::rsp_t out_data
);
  import rmth_pkg::*;

  cmd_t                  cmd;
  stat_t                 stat;
  logic [CountWidth-1:0] lower_count, upper_count;

  rmth_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cmd, .stat, .lower_count, .upper_count
  );

  rmth_datapath u_dp (
    .clk, .rst, .cmd, .stat, .lower_count, .upper_count
  );

`ifndef NO_ASSERTIONS
  // Heap balance holds whenever no request is in flight.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (upper_count == lower_count || upper_count == lower_count + 1'b1))
    else $error("heap counts out of balance");

  // No heap command is issued while a sift is running.
  assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> cmd.op == HOP_NONE)
    else $error("heap command while busy");

  // Input is never accepted while a result is pending.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
`endif

endmodule
